FILE: design/fmn_pkg.sv
package fmn_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BAUD  = 2'd0,
    CFG_SHIFT = 2'd1,
    CFG_MAP   = 2'd2
  } cfg_idx_e;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam logic [7:0] SymbolMapReset = 8'd27;

  // Quarter-wave series in Q30: odd terms of sin(pi/2 * x), C1 first
  localparam int QW = 31;
  localparam logic [QW-1:0] SERIES_COEF [6] = '{
    31'd1686629713, 31'd693598668, 31'd85569306,
    31'd5026995, 31'd172272, 31'd3864
  };

  // Sample queue between the phase front end and the sine back end
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

  // One lane of the polynomial pipeline (all Q30)
  typedef struct packed {
    logic [QW-1:0] x;
    logic [QW-1:0] x2;
    logic [QW-1:0] p;
  } lane_t;

  // Lane a evaluates S(u), lane b evaluates S(Q-u)
  typedef struct packed {
    lane_t      a;
    lane_t      b;
    logic [1:0] quad;
    logic       taken;
  } stage_t;

endpackage

FILE: design/fsk4_modulator_with_nco.sv
// Four-tone FSK modulator with an offset oscillator, complex baseband out.
// Input channel (in_valid_i/in_ready_o): one item per output sample, carrying
// the next two data bits; they are only consumed when the symbol clock wraps,
// and bits_taken_o on the matching output says so.
// Output channel (out_valid_o/out_ready_i): I/Q samples in Q(SAMPLE_BITS-1)
// with bits_taken_o, in input order, one per input item.
// Configuration: cfg_we_i writes register cfg_idx_i (0 baud step, 1 shift
// step, 2 symbol map) with cfg_wdata_i; write only while idle.
// Throughput: one item per clock while the queue has room. Each phase
// accumulator in the front end closes its loop through one register; the sine
// back end is a ten-stage pipeline (phase sum, square, five Horner steps,
// multiply by x, scaling, output register) with a 4-entry queue in front of it.
// An accepted item is written into the queue, then moves through the back-end
// stages in order to the output register.
// Reset clears all phases and the tone, the steps to zero and the symbol map
// to the identity mapping. When the receiver stalls, the pipeline holds, the
// queue fills and in_ready_o falls once it is full; nothing is dropped.
module fsk4_modulator_with_nco import fmn_pkg::*; #(
  parameter int PHASE_BITS    = 32,
  parameter int SAMPLE_BITS   = 16,
  parameter int LUT_ADDR_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             next_bits_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] i_sample_o,
  output logic [SAMPLE_BITS-1:0] q_sample_o,
  output logic                   bits_taken_o
);

  localparam int P  = PHASE_BITS;
  localparam int QD = 2 * P + 1;
  localparam logic [SAMPLE_BITS-1:0] MostNeg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic          push, pop, back_ready;
  logic [QD-1:0] push_data, pop_data;
  fifo_stat_t    fifo_stat;

  // Front end: symbol clock, tone choice, phase accumulators
  fmn_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .next_bits_i (next_bits_i),
    .full_i      (fifo_stat.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue of phase pairs between the two halves
  fmn_fifo #(
    .WIDTH (QD)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .pop_i   (pop),
    .rdata_o (pop_data),
    .stat_o  (fifo_stat)
  );

  assign pop = !fifo_stat.empty && back_ready;

  // Back end: cos/sin of the summed phase
  fmn_sine #(
    .PHASE_BITS    (PHASE_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .LUT_ADDR_BITS (LUT_ADDR_BITS)
  ) u_sine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (!fifo_stat.empty),
    .in_ready_o   (back_ready),
    .carrier_i    (pop_data[2*P-1:P]),
    .offset_i     (pop_data[P-1:0]),
    .taken_i      (pop_data[2*P]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .i_sample_o   (i_sample_o),
    .q_sample_o   (q_sample_o),
    .bits_taken_o (bits_taken_o)
  );

  // A quadrature pair never collapses to the origin
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (i_sample_o != '0 || q_sample_o != '0))
    else $error("I and Q both zero");

  // Magnitudes never exceed the amplitude, so the most negative code is unused
  a_no_most_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (i_sample_o != MostNeg && q_sample_o != MostNeg))
    else $error("sample reached the most negative code");

  // Queue occupancy follows pushes and pops
  a_fifo_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> fifo_stat.count == FIFO_CNT_W'($past(fifo_stat.count) + 1'b1))
    else $error("queue count did not rise on push");

  a_fifo_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> fifo_stat.count == FIFO_CNT_W'($past(fifo_stat.count) - 1'b1))
    else $error("queue count did not fall on pop");

endmodule

FILE: design/fmn_fifo.sv
module fmn_fifo import fmn_pkg::*; #(
  parameter int WIDTH = 65
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output fifo_stat_t       stat_o
);

  logic [WIDTH-1:0]      mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/fmn_front.sv
module fmn_front import fmn_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            next_bits_i,
  input  logic                  full_i,
  output logic                  push_o,
  output logic [2*PHASE_BITS:0] push_data_o
);

  localparam int P = PHASE_BITS;

  logic [P-1:0] baud_q, shift_q;
  logic [P-1:0] inc_q [4];
  logic [7:0]   symbol_map_q;
  logic [P-1:0] sym_q, carrier_q, offset_q;
  logic [1:0]   tone_q;

  logic [P-1:0] al_w, al3_w;
  logic         carry;
  logic [P-1:0] sym_d, carrier_d, offset_d;
  logic [1:0]   tone_d;

  // Align a 32-bit step to the phase width
  if (P >= 32) begin : g_up
    assign al_w = P'(cfg_wdata_i) << (P - 32);
  end else begin : g_dn
    assign al_w = P'(cfg_wdata_i >> (32 - P));
  end
  assign al3_w = al_w + (al_w << 1);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Advance the symbol clock and pick the tone on a carry
  always_comb begin
    {carry, sym_d} = {1'b0, sym_q} + {1'b0, baud_q};
    tone_d    = carry ? symbol_map_q[{~next_bits_i, 1'b0} +: 2] : tone_q;
    carrier_d = carrier_q + inc_q[tone_d];
    offset_d  = offset_q + shift_q;
  end

  assign push_data_o = {carry, carrier_d, offset_d};

  // Hold configuration and oscillator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baud_q       <= '0;
      shift_q      <= '0;
      symbol_map_q <= SymbolMapReset;
      for (int i = 0; i < 4; i++) begin
        inc_q[i] <= '0;
      end
      sym_q     <= '0;
      carrier_q <= '0;
      offset_q  <= '0;
      tone_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BAUD: begin
          baud_q    <= al_w;
          inc_q[0]  <= -al3_w;
          inc_q[1]  <= -al_w;
          inc_q[2]  <= al_w;
          inc_q[3]  <= al3_w;
          sym_q     <= '0;
          carrier_q <= '0;
          tone_q    <= '0;
        end
        CFG_SHIFT: begin
          shift_q  <= al_w;
          offset_q <= '0;
        end
        CFG_MAP: begin
          symbol_map_q <= cfg_wdata_i[7:0];
        end
        default: begin
        end
      endcase
    end else if (push_o) begin
      sym_q     <= sym_d;
      tone_q    <= tone_d;
      carrier_q <= carrier_d;
      offset_q  <= offset_d;
    end
  end

endmodule

FILE: design/fmn_sine.sv
module fmn_sine import fmn_pkg::*; #(
  parameter int PHASE_BITS    = 32,
  parameter int SAMPLE_BITS   = 16,
  parameter int LUT_ADDR_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PHASE_BITS-1:0]  carrier_i,
  input  logic [PHASE_BITS-1:0]  offset_i,
  input  logic                   taken_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] i_sample_o,
  output logic [SAMPLE_BITS-1:0] q_sample_o,
  output logic                   bits_taken_o
);

  localparam int P   = PHASE_BITS;
  localparam int L   = LUT_ADDR_BITS;
  localparam int SB  = SAMPLE_BITS;
  localparam int NST = 9;
  localparam int XSH = 30 - (L - 2);
  localparam logic [L-2:0]  QLEN  = (L-1)'(1) << (L - 2);
  localparam logic [63:0]   AMP64 = (64'd1 << (SB - 1)) - 64'd1;
  localparam logic [63:0]   RND64 = 64'd1 << 29;

  stage_t         st_q [NST];
  stage_t         st_d [NST];
  logic [NST-1:0] v_q, vin;
  logic [NST:0]   en;
  logic           out_valid_q;
  logic [SB-1:0]  i_q, q_q;
  logic           taken_q;
  logic [SB-2:0]  sa, sb, i_mag, q_mag;
  logic           i_neg, q_neg;

  function automatic logic [QW-1:0] mul_q30(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [2*QW-1:0] m;
    m = {{QW{1'b0}}, a} * {{QW{1'b0}}, b};
    return m[60:30];
  endfunction

  // Sum the phases and split the table address into quadrant and offset
  function automatic stage_t f_addr(input logic [P-1:0] c, input logic [P-1:0] o,
                                    input logic t);
    logic [P-1:0] ph;
    logic [L-1:0] addr;
    logic [L-3:0] u;
    logic [L-2:0] um;
    stage_t       s;
    ph      = c + o;
    addr    = ph[P-1 -: L];
    u       = addr[L-3:0];
    um      = QLEN - {1'b0, u};
    s.quad  = addr[L-1 -: 2];
    s.taken = t;
    s.a.x   = QW'(u) << XSH;
    s.b.x   = QW'(um) << XSH;
    s.a.x2  = '0;
    s.b.x2  = '0;
    s.a.p   = '0;
    s.b.p   = '0;
    return s;
  endfunction

  function automatic lane_t l_square(input lane_t l);
    lane_t r;
    r    = l;
    r.x2 = mul_q30(l.x, l.x);
    r.p  = SERIES_COEF[5];
    return r;
  endfunction

  function automatic lane_t l_horner(input lane_t l, input logic [QW-1:0] c);
    lane_t r;
    r   = l;
    r.p = c - mul_q30(l.p, l.x2);
    return r;
  endfunction

  function automatic lane_t l_mulx(input lane_t l);
    lane_t r;
    r   = l;
    r.p = mul_q30(l.p, l.x);
    return r;
  endfunction

  // Scale to full amplitude, round half up, clip at the amplitude
  function automatic lane_t l_scale(input lane_t l);
    logic [63:0] sc;
    lane_t       r;
    r  = l;
    sc = {{(64-QW){1'b0}}, l.p} * AMP64 + RND64;
    if (sc[63:30] > AMP64[33:0]) begin
      r.p = QW'(AMP64);
    end else begin
      r.p = sc[30+QW-1:30];
    end
    return r;
  endfunction

  // Per-stage work: address, square, five Horner steps, times x, scale
  assign st_d[0] = f_addr(carrier_i, offset_i, taken_i);
  assign st_d[1] = '{a: l_square(st_q[0].a), b: l_square(st_q[0].b),
                     quad: st_q[0].quad, taken: st_q[0].taken};
  for (genvar h = 0; h < 5; h++) begin : g_horner
    assign st_d[2+h] = '{a: l_horner(st_q[1+h].a, SERIES_COEF[4-h]),
                         b: l_horner(st_q[1+h].b, SERIES_COEF[4-h]),
                         quad: st_q[1+h].quad, taken: st_q[1+h].taken};
  end
  assign st_d[7] = '{a: l_mulx(st_q[6].a), b: l_mulx(st_q[6].b),
                     quad: st_q[6].quad, taken: st_q[6].taken};
  assign st_d[8] = '{a: l_scale(st_q[7].a), b: l_scale(st_q[7].b),
                     quad: st_q[7].quad, taken: st_q[7].taken};

  // Stall chain: a stage moves when it is empty or its successor moves
  assign en[NST] = !out_valid_q || out_ready_i;
  assign vin     = {v_q[NST-2:0], in_valid_i};
  for (genvar k = 0; k < NST; k++) begin : g_stage
    assign en[k] = !v_q[k] || en[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_ready_o = en[0];

  // Place magnitudes by quadrant and apply signs
  assign sa    = st_q[NST-1].a.p[SB-2:0];
  assign sb    = st_q[NST-1].b.p[SB-2:0];
  assign i_mag = st_q[NST-1].quad[0] ? sa : sb;
  assign q_mag = st_q[NST-1].quad[0] ? sb : sa;
  assign i_neg = st_q[NST-1].quad[0] ^ st_q[NST-1].quad[1];
  assign q_neg = st_q[NST-1].quad[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en[NST]) begin
      out_valid_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST]) begin
      i_q     <= i_neg ? -{1'b0, i_mag} : {1'b0, i_mag};
      q_q     <= q_neg ? -{1'b0, q_mag} : {1'b0, q_mag};
      taken_q <= st_q[NST-1].taken;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign i_sample_o   = i_q;
  assign q_sample_o   = q_q;
  assign bits_taken_o = taken_q;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fmn_pkg::*;

  localparam int PhaseW    = 32;
  localparam int SampleW   = 16;
  localparam int LutAddrW  = 10;
  localparam int QuarterN  = 1 << (LutAddrW - 2);
  localparam logic [63:0] Amplitude = (64'd1 << (SampleW - 1)) - 64'd1;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [SampleW-1:0] PosFull = 16'd32767;
  localparam logic [SampleW-1:0] NegFull = 16'h8001;
  localparam logic [SampleW-1:0] Zero    = 16'd0;

  localparam int NumPhases     = 6;
  localparam int ItemsPerPhase = 72;
  localparam int CalmPhase     = 2;
  localparam int HoldPhase     = 3;
  localparam int HoldLen       = 80;
  localparam int DrainCycles   = 14;
  localparam int StallLimit    = 1000;
  localparam int ReportMax     = 10;

  typedef enum logic [1:0] {TONE_M3, TONE_M1, TONE_P1, TONE_P3} tone_e;
  typedef enum logic [1:0] {QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH} quad_e;
  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_e;

  typedef struct packed {
    logic [SampleW-1:0] i_s;
    logic [SampleW-1:0] q_s;
    logic               taken;
  } sample_t;

  typedef struct {
    row_kind_e             kind;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   value;
    logic                  typed;
    sample_t               want;
  } stim_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i   = '0;
  logic [CfgDataW-1:0]    cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             next_bits_i = 2'd0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [SampleW-1:0]     i_sample_o;
  logic [SampleW-1:0]     q_sample_o;
  logic                   bits_taken_o;

  fsk4_modulator_with_nco #(
    .PHASE_BITS   (PhaseW),
    .SAMPLE_BITS  (SampleW),
    .LUT_ADDR_BITS(LutAddrW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .next_bits_i (next_bits_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .i_sample_o  (i_sample_o),
    .q_sample_o  (q_sample_o),
    .bits_taken_o(bits_taken_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Modulator state as the block should hold it
  logic [31:0] baud_q     = '0;
  logic [31:0] shift_q    = '0;
  logic [7:0]  map_q      = SymbolMapReset;
  logic [31:0] sym_phase  = '0;
  logic [31:0] carr_phase = '0;
  logic [31:0] offs_phase = '0;
  tone_e       tone       = TONE_M3;

  sample_t   expected_samples[$];
  stim_row_t stim_rows[$];
  int        mismatches  = 0;
  int        stall_count = 0;
  int        hold_count  = 0;
  logic      hold_req    = 1'b0;
  logic      hold_done   = 1'b0;
  logic      calm        = 1'b0;

  // Quarter-wave sine: odd series of sin(pi/2 * x) in Q30, scaled and saturated
  function automatic logic [SampleW-1:0] quarter_wave(input logic [63:0] u);
    logic [63:0] x, x2, p, s;
    x  = u << (30 - (LutAddrW - 2));
    x2 = (x * x) >> 30;
    p  = 64'd3864;
    p  = 64'd172272 - ((p * x2) >> 30);
    p  = 64'd5026995 - ((p * x2) >> 30);
    p  = 64'd85569306 - ((p * x2) >> 30);
    p  = 64'd693598668 - ((p * x2) >> 30);
    p  = 64'd1686629713 - ((p * x2) >> 30);
    p  = (p * x) >> 30;
    s  = (p * Amplitude + (64'd1 << 29)) >> 30;
    if (s > Amplitude) s = Amplitude;
    return s[SampleW-1:0];
  endfunction

  // Advance the phases by one sample and produce its I/Q pair
  function automatic sample_t modulate_sample(input logic [1:0] bits);
    logic [32:0]        sum;
    logic [31:0]        inc, phase;
    logic [7:0]         m;
    logic [LutAddrW-1:0] addr;
    logic [63:0]        u;
    logic [SampleW-1:0] sa, sb;
    sample_t            r;
    sum       = {1'b0, sym_phase} + {1'b0, baud_q};
    sym_phase = sum[31:0];
    r.taken   = sum[32];
    if (sum[32]) begin
      m    = map_q >> (6 - 2 * int'(bits));
      tone = tone_e'(m[1:0]);
    end
    case (tone)
      TONE_M3: inc = 32'd0 - 32'd3 * baud_q;
      TONE_M1: inc = 32'd0 - baud_q;
      TONE_P1: inc = baud_q;
      default: inc = 32'd3 * baud_q;
    endcase
    carr_phase = carr_phase + inc;
    offs_phase = offs_phase + shift_q;
    phase      = carr_phase + offs_phase;
    addr       = phase[PhaseW-1 -: LutAddrW];
    u          = {56'd0, addr[LutAddrW-3:0]};
    sa         = quarter_wave(u);
    sb         = quarter_wave(64'(QuarterN) - u);
    case (quad_e'(addr[LutAddrW-1 -: 2]))
      QUAD_FIRST: begin
        r.i_s = sb;
        r.q_s = sa;
      end
      QUAD_SECOND: begin
        r.i_s = -sa;
        r.q_s = sb;
      end
      QUAD_THIRD: begin
        r.i_s = -sb;
        r.q_s = -sa;
      end
      default: begin
        r.i_s = sa;
        r.q_s = -sb;
      end
    endcase
    return r;
  endfunction

  function automatic void add_write(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] value);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = value;
    row.typed = 1'b0;
    row.want  = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_item(input logic [1:0] bits, input logic typed,
                                   input logic [SampleW-1:0] i_s,
                                   input logic [SampleW-1:0] q_s,
                                   input logic taken);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.idx   = '0;
    row.value = {30'd0, bits};
    row.typed = typed;
    row.want  = '{i_s: i_s, q_s: q_s, taken: taken};
    stim_rows.push_back(row);
  endfunction

  // Write one register once the block has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BAUD: begin
        baud_q     = value;
        sym_phase  = '0;
        carr_phase = '0;
        tone       = TONE_M3;
      end
      CFG_SHIFT: begin
        shift_q    = value;
        offs_phase = '0;
      end
      CFG_MAP: map_q = value[7:0];
      default: ;
    endcase
  endtask

  // Offer one item, hold it until accepted, then log its expected sample
  task automatic send_bits(input logic [1:0] bits, input logic typed,
                           input sample_t want);
    sample_t predicted;
    while (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    next_bits_i <= bits;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = modulate_sample(bits);
    expected_samples.push_back(typed ? want : predicted);
  endtask

  // Receiver: random backpressure, one long hold-off, compare each sample
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin : compare
        sample_t got, want;
        got = '{i_s: i_sample_o, q_s: q_sample_o, taken: bits_taken_o};
        if (expected_samples.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= ReportMax)
            $display("unexpected sample: i %0d q %0d taken %0d",
                     $signed(got.i_s), $signed(got.q_s), got.taken);
        end else begin
          want = expected_samples.pop_front();
          if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= ReportMax)
              $display("sample mismatch: i %0d/%0d q %0d/%0d taken %0d/%0d (exp/got)",
                       $signed(want.i_s), $signed(got.i_s),
                       $signed(want.q_s), $signed(got.q_s),
                       want.taken, got.taken);
          end
        end
      end
      if (hold_count != 0) begin
        hold_count  <= hold_count - 1;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_count  <= HoldLen;
        hold_done   <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  // Watchdog: count cycles in which nothing moves
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int          phase_n, item_n;
    logic [31:0] baud_pick, shift_pick;

    // Idle after reset: zero phase gives full-scale cosine
    add_item(2'd3, 1'b1, PosFull, Zero, 1'b0);
    add_item(2'd0, 1'b1, PosFull, Zero, 1'b0);
    // Quarter-turn offset walks the four quadrants
    add_write(CFG_SHIFT, 32'h4000_0000);
    add_item(2'd1, 1'b1, Zero, PosFull, 1'b0);
    add_item(2'd2, 1'b1, NegFull, Zero, 1'b0);
    add_item(2'd3, 1'b1, Zero, NegFull, 1'b0);
    add_item(2'd0, 1'b1, PosFull, Zero, 1'b0);
    // Most negative shift: half a turn per sample
    add_write(CFG_SHIFT, 32'h8000_0000);
    add_item(2'd0, 1'b1, NegFull, Zero, 1'b0);
    add_item(2'd3, 1'b1, PosFull, Zero, 1'b0);
    // Largest baud step, identity map
    add_write(CFG_SHIFT, 32'h0000_0000);
    add_write(CFG_BAUD, 32'hFFFF_FFFF);
    add_item(2'd0, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd1, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd2, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd3, 1'b0, Zero, Zero, 1'b0);
    // All-zero map, upper data bits must be dropped
    add_write(CFG_MAP, 32'hFFFF_FF00);
    add_write(CFG_BAUD, 32'h8000_0000);
    add_item(2'd3, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd0, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd3, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd2, 1'b0, Zero, Zero, 1'b0);
    // Out-of-range index is ignored, then reversed map with top shift
    add_write(CfgUnused, 32'h1234_5678);
    add_write(CFG_MAP, 32'h0000_00E4);
    add_write(CFG_SHIFT, 32'h7FFF_FFFF);
    add_item(2'd0, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd1, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd2, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd3, 1'b0, Zero, Zero, 1'b0);
    // Slower symbols: bits between boundaries are ignored
    add_write(CFG_MAP, 32'd27);
    add_write(CFG_BAUD, 32'h4000_0000);
    add_item(2'd0, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd1, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd2, 1'b0, Zero, Zero, 1'b0);
    add_item(2'd3, 1'b0, Zero, Zero, 1'b0);

    // Hold reset, then release it
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_WRITE)
        write_reg(stim_rows[r].idx, stim_rows[r].value);
      else
        send_bits(stim_rows[r].value[1:0], stim_rows[r].typed, stim_rows[r].want);
    end

    // Random phases, each with fresh register settings
    for (phase_n = 0; phase_n < NumPhases; phase_n++) begin
      calm <= (phase_n == CalmPhase);
      case ($urandom_range(4))
        0:       baud_pick = 32'd0;
        1:       baud_pick = 32'hFFFF_FFFF;
        2:       baud_pick = $urandom_range(32'h0800_0000, 1);
        default: baud_pick = $urandom;
      endcase
      case ($urandom_range(3))
        0:       shift_pick = 32'h7FFF_FFFF;
        1:       shift_pick = 32'h8000_0000;
        2:       shift_pick = 32'd0;
        default: shift_pick = $urandom;
      endcase
      write_reg(CFG_SHIFT, shift_pick);
      write_reg(CFG_BAUD, baud_pick);
      write_reg(CFG_MAP, $urandom);
      if ($urandom_range(1) == 0) write_reg(CfgUnused, $urandom);
      for (item_n = 0; item_n < ItemsPerPhase; item_n++) begin
        if (phase_n == HoldPhase && item_n == 20) hold_req <= 1'b1;
        send_bits(2'($urandom_range(3)), 1'b0, '0);
      end
    end

    // Drain and decide
    in_valid_i <= 1'b0;
    calm       <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_samples.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
design/fmn_pkg.sv
design/fmn_fifo.sv
design/fmn_front.sv
design/fmn_sine.sv
design/fsk4_modulator_with_nco.sv
test/testbench.sv
